[rtl/core/hrbd_pkg.sv]
// ----------------------------------------------------------------------------
// hrbd_pkg
// Types, constants and byte-level parse functions for the HTTP response
// body deframer.
// ----------------------------------------------------------------------------
package hrbd_pkg;

  localparam int unsigned LINE_LIMIT        = 65536;
  localparam int unsigned HEADER_SCAN_LIMIT = 4095;
  localparam int unsigned POS_W             = $clog2(LINE_LIMIT + 1);
  localparam int unsigned NEED_W            = POS_W + 1;

  localparam logic [63:0] CLEN_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [9:0]  STATUS_MAX = 10'd999;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [3:0] {
    PH_STATUS  = 4'd0,
    PH_HEADERS = 4'd1,
    PH_CSIZE   = 4'd2,
    PH_CDATA   = 4'd3,
    PH_CTAIL   = 4'd4,
    PH_LBODY   = 4'd5,
    PH_LDONE   = 4'd6,
    PH_REST    = 4'd7,
    PH_DONE    = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    K_BODY = 2'd0,
    K_OK   = 2'd1,
    K_FAIL = 2'd2
  } kind_e;

  // number_substate codes
  localparam logic [2:0] NS_START = 3'd0;
  localparam logic [2:0] NS_CLEN  = 3'd1;
  localparam logic [2:0] NS_TE    = 3'd2;
  localparam logic [2:0] NS_CVAL  = 3'd3;
  localparam logic [2:0] NS_CDIG  = 3'd4;
  localparam logic [2:0] NS_CNEG  = 3'd5;
  localparam logic [2:0] NS_TVAL  = 3'd6;
  localparam logic [2:0] NS_SKIP  = 3'd7;
  // status / size line use: 0 lead, 1 digits, 2 stopped
  localparam logic [2:0] NS_DIG   = 3'd1;
  localparam logic [2:0] NS_STOP  = 3'd2;

  // per-line parse context
  typedef struct packed {
    logic [2:0]  sub;
    logic [4:0]  match;
    logic [63:0] acc;
    logic [63:0] rem;
    logic        len_known;
    logic        chunked;
  } ctx_t;

  typedef struct packed {
    logic  vld;
    kind_e kind;
    logic [7:0] data;
  } res_t;

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // bit 4 set when c is a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] l;
    l = lower(c);
    if (is_dec(c)) return {1'b1, c[3:0]};
    if (l >= 8'h61 && l <= 8'h66) return {1'b1, 4'(l - 8'h57)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] pfx_status(input logic [4:0] i);
    unique case (i)
      5'd0: return "H";
      5'd1: return "T";
      5'd2: return "T";
      5'd3: return "P";
      5'd4: return "/";
      5'd5: return "1";
      5'd6: return ".";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] pfx_clen(input logic [4:0] i);
    unique case (i)
      5'd0: return "c";  5'd1: return "o";  5'd2: return "n";  5'd3: return "t";
      5'd4: return "e";  5'd5: return "n";  5'd6: return "t";  5'd7: return "-";
      5'd8: return "l";  5'd9: return "e";  5'd10: return "n"; 5'd11: return "g";
      5'd12: return "t"; 5'd13: return "h"; 5'd14: return ":";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] pfx_te(input logic [4:0] i);
    unique case (i)
      5'd0: return "t";  5'd1: return "r";  5'd2: return "a";  5'd3: return "n";
      5'd4: return "s";  5'd5: return "f";  5'd6: return "e";  5'd7: return "r";
      5'd8: return "-";  5'd9: return "e";  5'd10: return "n"; 5'd11: return "c";
      5'd12: return "o"; 5'd13: return "d"; 5'd14: return "i"; 5'd15: return "n";
      5'd16: return "g"; 5'd17: return ":";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] word_chunked(input logic [4:0] i);
    unique case (i)
      5'd0: return "c"; 5'd1: return "h"; 5'd2: return "u"; 5'd3: return "n";
      5'd4: return "k"; 5'd5: return "e"; 5'd6: return "d";
      default: return 8'h00;
    endcase
  endfunction

  // One content byte of a status, header or chunk-size line.
  function automatic ctx_t content(input ctx_t cx, input phase_e ph,
                                   input logic [7:0] c, input logic [POS_W-1:0] idx);
    ctx_t        r;
    logic [7:0]  lc;
    logic [4:0]  hv;
    logic [13:0] st;
    logic [67:0] prod;
    logic [3:0]  dv;
    r    = cx;
    lc   = lower(c);
    hv   = hex_val(c);
    dv   = c[3:0];
    st   = 14'(cx.acc[9:0]) * 14'd10 + 14'(dv);
    prod = 68'(cx.rem) * 68'd10 + 68'(dv);
    if (idx >= POS_W'(HEADER_SCAN_LIMIT)) return r;
    if (ph == PH_STATUS) begin
      if (idx < POS_W'(7)) begin
        if (POS_W'(cx.match) == idx && c == pfx_status(cx.match)) r.match = cx.match + 5'd1;
      end else if (idx < POS_W'(9)) begin
        if (c == 8'h00) r.sub = NS_STOP;
      end else if (cx.sub == NS_START) begin
        if (c == "+") r.sub = NS_DIG;
        else if (is_dec(c)) begin
          r.sub = NS_DIG;
          r.acc = 64'((st > 14'(STATUS_MAX)) ? 14'(STATUS_MAX) : st);
        end else if (!is_ws(c)) r.sub = NS_STOP;
      end else if (cx.sub == NS_DIG) begin
        if (!is_dec(c)) r.sub = NS_STOP;
        else r.acc = 64'((st > 14'(STATUS_MAX)) ? 14'(STATUS_MAX) : st);
      end
    end else if (ph == PH_HEADERS) begin
      unique case (cx.sub)
        NS_START: begin
          if (idx != '0) r.sub = NS_SKIP;
          else if (lc == "c") begin r.sub = NS_CLEN; r.match = 5'd1; end
          else if (lc == "t") begin r.sub = NS_TE; r.match = 5'd1; end
          else r.sub = NS_SKIP;
        end
        NS_CLEN: begin
          if (cx.match < 5'd15 && lc == pfx_clen(cx.match)) begin
            r.match = cx.match + 5'd1;
            if (r.match == 5'd15) begin
              r.sub = NS_CVAL; r.len_known = 1'b1; r.rem = '0;
            end
          end else r.sub = NS_SKIP;
        end
        NS_TE: begin
          if (cx.match < 5'd18 && lc == pfx_te(cx.match)) begin
            r.match = cx.match + 5'd1;
            if (r.match == 5'd18) begin r.sub = NS_TVAL; r.match = '0; end
          end else r.sub = NS_SKIP;
        end
        NS_CVAL, NS_CDIG: begin
          if (cx.sub == NS_CVAL && is_ws(c)) r.sub = cx.sub;
          else if (cx.sub == NS_CVAL && c == "+") r.sub = NS_CDIG;
          else if (cx.sub == NS_CVAL && c == "-") r.sub = NS_CNEG;
          else if (!is_dec(c)) r.sub = NS_SKIP;
          else begin
            r.sub = NS_CDIG;
            r.rem = (prod > 68'(CLEN_MAX)) ? CLEN_MAX : prod[63:0];
          end
        end
        NS_CNEG: begin
          if (c != "0") begin
            if (is_dec(c)) r.len_known = 1'b0;
            r.sub = NS_SKIP;
          end
        end
        NS_TVAL: begin
          if (c == 8'h00) r.sub = NS_SKIP;
          else if (cx.match < 5'd7 && lc == word_chunked(cx.match)) begin
            r.match = cx.match + 5'd1;
            if (r.match == 5'd7) begin r.chunked = 1'b1; r.sub = NS_SKIP; end
          end else r.match = (lc == "c") ? 5'd1 : 5'd0;
        end
        default: ;
      endcase
    end else if (ph == PH_CSIZE) begin
      if (cx.sub == NS_START) begin
        if (hv[4]) begin
          r.sub = NS_DIG;
          r.acc = (cx.acc[63:60] != '0) ? '1 : {cx.acc[59:0], hv[3:0]};
        end else if (!is_ws(c)) r.sub = NS_STOP;
      end else if (cx.sub == NS_DIG) begin
        if (!hv[4]) r.sub = NS_STOP;
        else r.acc = (cx.acc[63:60] != '0) ? '1 : {cx.acc[59:0], hv[3:0]};
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/hrbd_step.sv]
// ----------------------------------------------------------------------------
// hrbd_step
// Deframer state and the per-byte update: line framing, header scan and
// body framing. Gives at most one result for each stepped byte.
// ----------------------------------------------------------------------------
module hrbd_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              end_i,
  output hrbd_pkg::res_t    res_o,
  output logic [9:0]        status_o
);
  import hrbd_pkg::*;

  phase_e            phase_q, phase_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              pend_q, pend_d;
  ctx_t              cx_q, cx_d, cx_cr;
  logic [9:0]        status_q, status_d;
  logic              line_fail, line_ok, is_line, is_eol;
  logic [NEED_W-1:0] need;

  assign is_line = (phase_q == PH_STATUS) || (phase_q == PH_HEADERS) ||
                   (phase_q == PH_CSIZE) || (phase_q == PH_CTAIL);
  assign is_eol  = pend_q && byte_i == CH_LF;
  assign need    = NEED_W'(pos_q) + ((byte_i == CH_CR) ? NEED_W'(2) : NEED_W'(3));
  // a held CR turns out to be line content
  assign cx_cr   = pend_q ? content(cx_q, phase_q, CH_CR, pos_q - POS_W'(1)) : cx_q;

  // next state
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    pend_d    = pend_q;
    cx_d      = cx_q;
    status_d  = status_q;
    line_fail = 1'b0;
    line_ok   = 1'b0;
    if (step_i && phase_q != PH_DONE) begin
      if (end_i) phase_d = PH_DONE;
      else begin
        unique case (phase_q)
          PH_CDATA, PH_LBODY: begin
            if (cx_q.rem != '0) cx_d.rem = cx_q.rem - 64'd1;
            if (cx_d.rem == '0) begin
              if (phase_q == PH_CDATA) begin
                phase_d = PH_CTAIL;
                pos_d = '0; pend_d = 1'b0; cx_d.match = '0; cx_d.sub = '0; cx_d.acc = '0;
              end else phase_d = PH_LDONE;
            end
          end
          PH_LDONE: phase_d = PH_DONE;
          PH_REST:  ;
          default: begin
            if (is_eol) begin
              pos_d = '0; pend_d = 1'b0; cx_d.match = '0; cx_d.sub = '0; cx_d.acc = '0;
              unique case (phase_q)
                PH_STATUS: begin
                  if (cx_q.match != 5'd7) line_fail = 1'b1;
                  else begin
                    status_d = cx_q.acc[9:0];
                    phase_d  = PH_HEADERS;
                  end
                end
                PH_HEADERS: begin
                  if (pos_q == POS_W'(1)) begin
                    if (cx_q.chunked) phase_d = PH_CSIZE;
                    else if (cx_q.len_known) begin
                      if (cx_q.rem == '0) line_ok = 1'b1;
                      else phase_d = PH_LBODY;
                    end else phase_d = PH_REST;
                  end
                end
                PH_CSIZE: begin
                  if (cx_q.acc == '0) line_ok = 1'b1;
                  else begin
                    cx_d.rem = cx_q.acc;
                    phase_d  = PH_CDATA;
                  end
                end
                default: phase_d = PH_CSIZE;
              endcase
              if (line_fail || line_ok) phase_d = PH_DONE;
            end else if (need > NEED_W'(LINE_LIMIT)) begin
              line_fail = 1'b1;
              phase_d   = PH_DONE;
            end else begin
              pos_d = pos_q + POS_W'(1);
              if (byte_i == CH_CR) begin
                pend_d = 1'b1;
                cx_d   = cx_cr;
              end else begin
                pend_d = 1'b0;
                cx_d   = content(cx_cr, phase_q, byte_i, pos_q);
              end
            end
          end
        endcase
      end
    end
  end

  // result
  always_comb begin
    res_o = '{vld: 1'b0, kind: K_BODY, data: 8'h00};
    if (step_i && phase_q != PH_DONE) begin
      if (end_i) begin
        res_o.vld  = 1'b1;
        res_o.kind = (phase_q == PH_REST || phase_q == PH_LDONE) ? K_OK : K_FAIL;
      end else if (phase_q == PH_CDATA || phase_q == PH_LBODY || phase_q == PH_REST) begin
        res_o.vld  = 1'b1;
        res_o.data = byte_i;
      end else if (phase_q == PH_LDONE || line_ok) begin
        res_o.vld  = 1'b1;
        res_o.kind = K_OK;
      end else if (line_fail && is_line) begin
        res_o.vld  = 1'b1;
        res_o.kind = K_FAIL;
      end
    end
  end

  assign status_o = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_STATUS;
      pos_q    <= '0;
      pend_q   <= 1'b0;
      cx_q     <= '0;
      status_q <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      pend_q   <= pend_d;
      cx_q     <= cx_d;
      status_q <= status_d;
    end
  end

endmodule

[rtl/core/http_response_body_deframer.sv]
// ----------------------------------------------------------------------------
// http_response_body_deframer
// Parses an HTTP/1.x response byte stream and emits body bytes and a verdict.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                       tuser
//  s_axis    in   rx_byte[7:0]                end_mark
//  m_axis    out  body_byte[7:0], status[17:8] kind[1:0]
//
// One word per cycle while the output is not stalled; each byte is parsed in
// the cycle it is accepted and its result lands in the output register on that edge.
// Input is taken while the output register is empty or being drained.
// Reset returns to the status-line phase; after the verdict all words are
// consumed silently until reset.
module http_response_body_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] end_mark
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] body_byte, [17:8] status_code, zero pad
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);
  import hrbd_pkg::*;

  res_t       res;
  logic [9:0] status;
  logic       acc_in;
  logic       out_vld_q, out_vld_d;
  logic [1:0] kind_q;
  logic [7:0] data_q;
  logic [9:0] stat_q;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign acc_in        = s_axis_tvalid && s_axis_tready;

  hrbd_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (acc_in),
    .byte_i   (s_axis_tdata),
    .end_i    (s_axis_tuser),
    .res_o    (res),
    .status_o (status)
  );

  assign out_vld_d = acc_in ? res.vld : (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else         out_vld_q <= out_vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && res.vld) begin
      kind_q <= res.kind;
      data_q <= res.data;
      stat_q <= status;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, stat_q, data_q};
  assign m_axis_tuser  = kind_q;

endmodule

[rtl/core/hrbd_checker.sv]
// ----------------------------------------------------------------------------
// hrbd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module hrbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import hrbd_pkg::*;

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else if (m_axis_tvalid && m_axis_tready && m_axis_tuser != K_BODY) done_q <= 1'b1;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  a_one_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !m_axis_tvalid)
    else $error("word after verdict");

  a_verdict_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != K_BODY |-> m_axis_tdata[7:0] == 8'h00)
    else $error("verdict carries data");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[17:8] <= STATUS_MAX && m_axis_tuser != 2'd3)
    else $error("bad status or kind");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind http_response_body_deframer hrbd_checker u_hrbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for http_response_body_deframer. One response is fed
// byte by byte: status line, a mixed header block with chunked framing, a long
// run of random chunks, the closing zero chunk, then words after the verdict.
// Every accepted word is run through a local parser model and each output word
// is compared with the oldest expected one, under varied idle and stall rates.
// ----------------------------------------------------------------------------
module tb;
  import hrbd_pkg::*;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    logic [9:0] status;
  } out_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  out_word_t expected_words[$];
  int        mismatches = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        bytes_sent = 0;

  // parser model state
  phase_e      ph;
  int unsigned lpos;
  bit          pcr;
  logic [4:0]  mprog;
  bit          chunked, len_known;
  logic [63:0] acc, remaining;
  logic [9:0]  status_q;
  logic [2:0]  sub;

  http_response_body_deframer dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(negedge clk_i) begin
    out_word_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word kind=%0d data=%h", m_axis_tuser,
                                       m_axis_tdata);
      end else begin
        e = expected_words.pop_front();
        if (m_axis_tuser != e.kind || m_axis_tdata[7:0] != e.data ||
            m_axis_tdata[17:8] != e.status || m_axis_tdata[23:18] != '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind=%0d byte=%h st=%0d, got kind=%0d byte=%h st=%0d",
                     e.kind, e.data, e.status, m_axis_tuser, m_axis_tdata[7:0],
                     m_axis_tdata[17:8]);
        end
      end
    end
  end

  function automatic logic [7:0] lc_of(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction
  function automatic bit ws(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic bit dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic int hexv(logic [7:0] c);
    logic [7:0] l;
    l = lc_of(c);
    if (dec(c)) return c - "0";
    if (l >= "a" && l <= "f") return l - "a" + 10;
    return -1;
  endfunction

  task automatic push_word(kind_e k, logic [7:0] d);
    out_word_t w;
    w.kind = k; w.data = (k == K_BODY) ? d : 8'h00; w.status = status_q;
    expected_words.push_back(w);
  endtask

  task automatic finish_with(kind_e k);
    ph = PH_DONE;
    push_word(k, 8'h00);
  endtask

  task automatic new_line();
    lpos = 0; pcr = 0; mprog = 0; sub = NS_START; acc = 0;
  endtask

  task automatic parse_content(logic [7:0] c, int unsigned idx);
    string clen, te, chk, sp;
    logic [7:0] l;
    int d;
    clen = "content-length:"; te = "transfer-encoding:"; chk = "chunked";
    sp = "HTTP/1.";
    l = lc_of(c);
    d = hexv(c);
    if (idx >= HEADER_SCAN_LIMIT) return;
    if (ph == PH_STATUS) begin
      if (idx < 7) begin
        if (mprog == idx && c == sp[idx]) mprog++;
      end else if (idx < 9) begin
        if (c == 8'h00) sub = NS_STOP;
      end else begin
        if (sub == NS_START) begin
          if (ws(c)) return;
          if (c == "+") begin sub = NS_DIG; return; end
          if (!dec(c)) begin sub = NS_STOP; return; end
          sub = NS_DIG;
        end
        if (sub == NS_DIG) begin
          if (!dec(c)) begin sub = NS_STOP; return; end
          acc = acc * 10 + (c - "0");
          if (acc > 999) acc = 999;
        end
      end
    end else if (ph == PH_HEADERS) begin
      case (sub)
        NS_START: begin
          if (idx != 0) sub = NS_SKIP;
          else if (l == "c") begin sub = NS_CLEN; mprog = 1; end
          else if (l == "t") begin sub = NS_TE; mprog = 1; end
          else sub = NS_SKIP;
        end
        NS_CLEN: begin
          if (mprog < 15 && l == clen[mprog]) begin
            mprog++;
            if (mprog == 15) begin sub = NS_CVAL; len_known = 1; remaining = 0; end
          end else sub = NS_SKIP;
        end
        NS_TE: begin
          if (mprog < 18 && l == te[mprog]) begin
            mprog++;
            if (mprog == 18) begin sub = NS_TVAL; mprog = 0; end
          end else sub = NS_SKIP;
        end
        NS_CVAL, NS_CDIG: begin
          if (sub == NS_CVAL && ws(c)) ;
          else if (sub == NS_CVAL && c == "+") sub = NS_CDIG;
          else if (sub == NS_CVAL && c == "-") sub = NS_CNEG;
          else if (!dec(c)) sub = NS_SKIP;
          else begin
            sub = NS_CDIG;
            if (remaining > (CLEN_MAX - (c - "0")) / 10) remaining = CLEN_MAX;
            else remaining = remaining * 10 + (c - "0");
          end
        end
        NS_CNEG: begin
          if (c != "0") begin
            if (dec(c)) len_known = 0;
            sub = NS_SKIP;
          end
        end
        NS_TVAL: begin
          if (c == 8'h00) sub = NS_SKIP;
          else if (mprog < 7 && l == chk[mprog]) begin
            mprog++;
            if (mprog == 7) begin chunked = 1; sub = NS_SKIP; end
          end else mprog = (l == "c") ? 5'd1 : 5'd0;
        end
        default: ;
      endcase
    end else if (ph == PH_CSIZE) begin
      if (sub == NS_START) begin
        if (ws(c)) return;
        if (d < 0) begin sub = NS_STOP; return; end
        sub = NS_DIG;
      end
      if (sub == NS_DIG) begin
        if (d < 0) begin sub = NS_STOP; return; end
        if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 16) acc = '1;
        else acc = acc * 16 + d;
      end
    end
  endtask

  task automatic end_of_line();
    case (ph)
      PH_STATUS: begin
        if (mprog != 7) finish_with(K_FAIL);
        else begin status_q = acc[9:0]; ph = PH_HEADERS; new_line(); end
      end
      PH_HEADERS: begin
        int unsigned len;
        len = lpos - 1;
        new_line();
        if (len == 0) begin
          if (chunked) ph = PH_CSIZE;
          else if (len_known) begin
            if (remaining == 0) finish_with(K_OK);
            else ph = PH_LBODY;
          end else ph = PH_REST;
        end
      end
      PH_CSIZE: begin
        if (acc == 0) finish_with(K_OK);
        else begin remaining = acc; ph = PH_CDATA; new_line(); end
      end
      default: begin ph = PH_CSIZE; new_line(); end
    endcase
  endtask

  // expected output for one accepted input word
  task automatic predict_deframe(logic [7:0] c, bit end_mark);
    if (ph == PH_DONE) return;
    if (end_mark) begin
      finish_with((ph == PH_REST || ph == PH_LDONE) ? K_OK : K_FAIL);
      return;
    end
    case (ph)
      PH_CDATA: begin
        push_word(K_BODY, c);
        if (remaining != 0) remaining--;
        if (remaining == 0) begin ph = PH_CTAIL; new_line(); end
      end
      PH_LBODY: begin
        push_word(K_BODY, c);
        if (remaining != 0) remaining--;
        if (remaining == 0) ph = PH_LDONE;
      end
      PH_LDONE: finish_with(K_OK);
      PH_REST: push_word(K_BODY, c);
      default: begin
        if (pcr && c == CH_LF) end_of_line();
        else if (lpos + 1 + ((c == CH_CR) ? 1 : 2) > LINE_LIMIT) finish_with(K_FAIL);
        else begin
          if (pcr) parse_content(CH_CR, lpos - 1);
          if (c == CH_CR) begin pcr = 1; lpos++; end
          else begin pcr = 0; parse_content(c, lpos); lpos++; end
        end
      end
    endcase
  endtask

  task automatic send_word(logic [7:0] c, bit end_mark);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= end_mark;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    predict_deframe(c, end_mark);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_word(s[i], 1'b0);
  endtask

  task automatic test_status_line();
    // lone CR inside the reason text, padded status that saturates
    send_text("HTTP/1.1  \t+2005 O\rK\n!\r\n");
  endtask

  task automatic test_headers();
    send_text("Content-Length: -0\r\n");
    send_text("content-LENGTH:+123\r\n");
    send_text("CONTENT-LENGTH: -5\r\n");
    send_text("Content-Length: 99999999999999999999999\r\n");
    send_word(8'h00, 1'b0);
    send_text("Content-Length: 7\r\n");
    send_text("X-Note: a\nb");
    send_word(8'h00, 1'b0);
    send_text("c\r\n");
    send_text("Transfer-Encoding:");
    send_word(8'h00, 1'b0);
    send_text("chunked\r\n");
    send_text("Transfer-Encoding: gzip, cchUNKED\r\n");
    send_text("\r\n");
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(126, 32));
  endfunction

  task automatic test_random_chunks();
    int n;
    string sz;
    for (int phase_no = 0; phase_no < 4; phase_no++) begin
      idle_pct  = (phase_no == 1) ? 86 : 0;
      stall_pct = (phase_no == 2) ? 86 : 0;
      if (phase_no == 3) begin idle_pct = 14; stall_pct = 14; end
      while (bytes_sent < 260 * (phase_no + 1)) begin
        n  = $urandom_range(1, 40);
        sz = $sformatf("%0h", n);
        if ($urandom_range(1)) sz = sz.toupper();
        if ($urandom_range(3) == 0) sz = {"000", sz};
        repeat ($urandom_range(2)) send_word(($urandom_range(1)) ? " " : 8'h09, 1'b0);
        send_text(sz);
        if ($urandom_range(2) == 0) send_text(";ext=z");
        send_text("\r\n");
        repeat (n) send_word(8'($urandom), 1'b0);
        repeat ($urandom_range(3)) send_word(printable(), 1'b0);
        send_text("\r\n");
      end
    end
  endtask

  task automatic test_last_chunk_and_after();
    idle_pct = 0; stall_pct = 0;
    send_text(" 00;x\r\n");
    send_text("Trailer: ignored\r\n");
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
  endtask

  initial begin
    ph = PH_STATUS; new_line();
    chunked = 0; len_known = 0; remaining = 0; status_q = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_status_line();
    test_headers();
    test_random_chunks();
    test_last_chunk_and_after();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
rtl/core/hrbd_pkg.sv
rtl/core/hrbd_step.sv
rtl/core/http_response_body_deframer.sv
rtl/core/hrbd_checker.sv
tb/tb.sv
